@@ hdl/cne_pkg.sv @@
// Shared types and constants for the CSR neighbor expansion block.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package cne_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned NBR_W    = 12;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned COL_W    = 16;
  localparam int unsigned WEIGHT_W = 17;

  // Batch bookkeeping
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned EDGE_W    = 16;
  localparam int unsigned BASE_W    = 17;   // batch length + edge counter
  localparam int unsigned IDX_W     = 17;   // pointer + offset, table read index
  localparam logic [CNT_W-1:0] BATCH_MAX = 13'd8191;

  // Parameter defaults for the top level
  localparam int unsigned NODE_COUNT_DEF       = 4096;
  localparam int unsigned EDGE_COUNT_DEF       = 32768;
  localparam int unsigned MAX_DEGREE_DEF       = 64;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 16;

  // Input item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PTR_WR = 2'd0,
    KIND_NBR_WR = 2'd1,
    KIND_BEGIN  = 2'd2,
    KIND_EXPAND = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_DEGREE   = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  // Expansion sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTR_B,
    ST_PTR_E,
    ST_CHECK,
    ST_NOUT,
    ST_STATUS
  } state_t;

  // Table write ports
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VALUE_W-1:0] data;
  } ptr_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [NBR_W-1:0]  data;
  } nbr_wr_t;

  // Table read ports
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } tbl_rd_t;

endpackage

`default_nettype wire

@@ hdl/cne_if.sv @@
// Valid/ready channel interfaces for the item and result streams.
// Depends on cne_pkg for field widths and code types.
`default_nettype none

interface cne_in_if;
  logic                          valid;
  logic                          ready;
  cne_pkg::kind_t                kind;
  logic [cne_pkg::ADDR_W-1:0]    address;
  logic [cne_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output kind, output address, output value, input ready);
  modport sink   (input valid, input kind, input address, input value, output ready);
endinterface

interface cne_out_if;
  logic                          valid;
  logic                          ready;
  logic [cne_pkg::NBR_W-1:0]     neighbor;
  logic [cne_pkg::ROW_W-1:0]     row;
  logic [cne_pkg::COL_W-1:0]     column;
  logic [cne_pkg::WEIGHT_W-1:0]  weight;
  cne_pkg::status_t              status;
  logic                          last;

  modport source (output valid, output neighbor, output row, output column,
                  output weight, output status, output last, input ready);
  modport sink   (input valid, input neighbor, input row, input column,
                  input weight, input status, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/cne_ptr_store.sv @@
// Row pointer table: NODE_COUNT+1 entries, one write and one read port,
// registered read data. Depends on cne_pkg.
`default_nettype none

module cne_ptr_store #(
  parameter int unsigned NODE_COUNT = cne_pkg::NODE_COUNT_DEF
) (
  input  wire                           clk,
  input  wire  cne_pkg::ptr_wr_t        wr,
  input  wire  cne_pkg::tbl_rd_t        rd,
  output logic [cne_pkg::VALUE_W-1:0]   rd_data
);

  localparam int unsigned DEPTH = NODE_COUNT + 1;
  localparam int unsigned PA_W  = $clog2(DEPTH);

  logic [cne_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [cne_pkg::VALUE_W-1:0] rd_data_r;

  // Write; addresses past the last entry are dropped
  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.addr) <= NODE_COUNT)) begin
      mem[PA_W'(wr.addr)] <= wr.data;
    end
  end

  // Read; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[PA_W'(rd.idx)];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hdl/cne_nbr_store.sv @@
// Neighbor table: EDGE_COUNT entries of 12 bits, one write and one read port,
// registered read data; an index past the table reads as zero. Depends on cne_pkg.
`default_nettype none

module cne_nbr_store #(
  parameter int unsigned EDGE_COUNT = cne_pkg::EDGE_COUNT_DEF
) (
  input  wire                          clk,
  input  wire  cne_pkg::nbr_wr_t       wr,
  input  wire  cne_pkg::tbl_rd_t       rd,
  output logic [cne_pkg::NBR_W-1:0]    rd_data
);

  localparam int unsigned NA_W = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;

  logic [cne_pkg::NBR_W-1:0] mem [EDGE_COUNT];
  logic [cne_pkg::NBR_W-1:0] mem_q_r;
  logic                      in_range_r;

  // Write; out-of-range addresses are dropped
  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.addr) < EDGE_COUNT)) begin
      mem[NA_W'(wr.addr)] <= wr.data;
    end
  end

  // Read with range flag, both held between reads
  always_ff @(posedge clk) begin
    if (rd.en) begin
      mem_q_r    <= mem[NA_W'(rd.idx)];
      in_range_r <= (32'(rd.idx) < EDGE_COUNT);
    end
  end

  assign rd_data = in_range_r ? mem_q_r : '0;

endmodule

`default_nettype wire

@@ hdl/csr_neighbor_expand.sv @@
// Top level: item decode, expansion sequencer, batch counters and result register.
// Depends on cne_pkg, cne_if, cne_ptr_store and cne_nbr_store.
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    kind, address, value
//  out_ch   out  valid/ready    neighbor, row, column, weight, status, last
//
// Write and begin-batch items are taken in the idle state. An expand item holds
// the sequencer through two pointer reads, a check step, then one neighbor-table
// read per result; a status result follows the check, or comes straight from idle
// when the seed is out of range. Result stalls on out_ch stop the neighbor reads.
// Synchronous active-low reset clears the sequencer and batch counters; the
// tables are not cleared and must be written before use.
`default_nettype none

module csr_neighbor_expand #(
  parameter int unsigned NODE_COUNT       = cne_pkg::NODE_COUNT_DEF,
  parameter int unsigned EDGE_COUNT       = cne_pkg::EDGE_COUNT_DEF,
  parameter int unsigned MAX_DEGREE       = cne_pkg::MAX_DEGREE_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = cne_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  cne_in_if.sink     in_ch,
  cne_out_if.source  out_ch
);

  localparam int unsigned DEG_W1 = $clog2(MAX_DEGREE + 1);
  localparam int unsigned DEG_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  // Inverse-degree table, entry d-1 holds floor(2^WEIGHT_FRAC_BITS / d)
  logic [cne_pkg::WEIGHT_W-1:0] weight_tab [MAX_DEGREE];

  for (genvar d = 0; d < MAX_DEGREE; d++) begin : g_wtab
    localparam logic [63:0] QUOT = (64'd1 << WEIGHT_FRAC_BITS) / 64'(d + 1);
    assign weight_tab[d] = QUOT[cne_pkg::WEIGHT_W-1:0];
  end

  // Sequencer and datapath registers
  cne_pkg::state_t                state_r, state_nxt;
  cne_pkg::status_t               status_r;
  logic [cne_pkg::VALUE_W-1:0]    seed_r;
  logic [cne_pkg::ROW_W-1:0]      row_r;
  logic [cne_pkg::BASE_W-1:0]     base_r;
  logic [cne_pkg::VALUE_W-1:0]    begin_r;
  logic [DEG_W1-1:0]              deg_r;
  logic [DEG_W1-1:0]              rem_r;
  logic [cne_pkg::WEIGHT_W-1:0]   weight_r;
  logic [cne_pkg::IDX_W-1:0]      nbr_idx_r;
  logic [cne_pkg::COL_W-1:0]      col_r;

  // Batch counters
  logic [cne_pkg::CNT_W-1:0]      batch_len_r;
  logic [cne_pkg::CNT_W-1:0]      row_cnt_r;
  logic [cne_pkg::EDGE_W-1:0]     edge_cnt_r;

  // Result register
  logic                           out_valid_r;
  logic [cne_pkg::NBR_W-1:0]      out_nbr_r;
  logic [cne_pkg::ROW_W-1:0]      out_row_r;
  logic [cne_pkg::COL_W-1:0]      out_col_r;
  logic [cne_pkg::WEIGHT_W-1:0]   out_weight_r;
  cne_pkg::status_t               out_status_r;
  logic                           out_last_r;

  // Control
  logic                           in_ready;
  logic                           in_fire;
  logic                           seed_bad;
  logic                           out_free;
  logic                           out_load;
  logic                           rem_last;
  logic                           check_ok;
  logic                           col_ovf;
  logic                           ptr_empty;
  logic                           deg_big;
  logic [cne_pkg::IDX_W-1:0]      ptr_diff;
  cne_pkg::ptr_wr_t               ptr_wr;
  cne_pkg::nbr_wr_t               nbr_wr;
  cne_pkg::tbl_rd_t               ptr_rd;
  cne_pkg::tbl_rd_t               nbr_rd;
  logic [cne_pkg::VALUE_W-1:0]    ptr_rd_data;
  logic [cne_pkg::NBR_W-1:0]      nbr_rd_data;

  // Table memories
  cne_ptr_store #(.NODE_COUNT(NODE_COUNT)) u_ptr_store (
    .clk     (clk),
    .wr      (ptr_wr),
    .rd      (ptr_rd),
    .rd_data (ptr_rd_data)
  );

  cne_nbr_store #(.EDGE_COUNT(EDGE_COUNT)) u_nbr_store (
    .clk     (clk),
    .wr      (nbr_wr),
    .rd      (nbr_rd),
    .rd_data (nbr_rd_data)
  );

  // Handshake and decode helpers
  assign in_fire  = in_ch.valid && in_ready;
  assign seed_bad = 32'(in_ch.value) >= NODE_COUNT;
  assign out_free = !out_valid_r || out_ch.ready;
  assign rem_last = (rem_r == DEG_W1'(1));

  // Degree from the two pointers (pointer data valid in ST_PTR_E)
  assign ptr_diff  = {1'b0, ptr_rd_data} - {1'b0, begin_r};
  assign ptr_empty = ptr_rd_data <= begin_r;
  assign deg_big   = ptr_diff > cne_pkg::IDX_W'(MAX_DEGREE);

  // Column range: base + deg - 1 must stay within 16 bits
  assign col_ovf  = (18'(base_r) + 18'(deg_r)) > 18'd65536;
  assign check_ok = (status_r == cne_pkg::STAT_OK) && !col_ovf;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cne_pkg::ST_IDLE: begin
        if (in_fire && in_ch.kind == cne_pkg::KIND_EXPAND) begin
          state_nxt = seed_bad ? cne_pkg::ST_STATUS : cne_pkg::ST_PTR_B;
        end
      end
      cne_pkg::ST_PTR_B:  state_nxt = cne_pkg::ST_PTR_E;
      cne_pkg::ST_PTR_E:  state_nxt = cne_pkg::ST_CHECK;
      cne_pkg::ST_CHECK:  state_nxt = check_ok ? cne_pkg::ST_NOUT : cne_pkg::ST_STATUS;
      cne_pkg::ST_NOUT: begin
        if (out_load && rem_last) begin
          state_nxt = cne_pkg::ST_IDLE;
        end
      end
      cne_pkg::ST_STATUS: begin
        if (out_load) begin
          state_nxt = cne_pkg::ST_IDLE;
        end
      end
      default:            state_nxt = cne_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, table ports, result load
  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    ptr_wr.en    = 1'b0;
    ptr_wr.addr  = in_ch.address;
    ptr_wr.data  = in_ch.value;
    nbr_wr.en    = 1'b0;
    nbr_wr.addr  = in_ch.address;
    nbr_wr.data  = in_ch.value[cne_pkg::NBR_W-1:0];
    ptr_rd.en    = 1'b0;
    ptr_rd.idx   = cne_pkg::IDX_W'(in_ch.value);
    nbr_rd.en    = 1'b0;
    nbr_rd.idx   = nbr_idx_r;
    unique case (state_r)
      cne_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          unique case (in_ch.kind)
            cne_pkg::KIND_PTR_WR: ptr_wr.en = 1'b1;
            cne_pkg::KIND_NBR_WR: nbr_wr.en = 1'b1;
            cne_pkg::KIND_BEGIN:  ;
            cne_pkg::KIND_EXPAND: ptr_rd.en = !seed_bad;
          endcase
        end
      end
      cne_pkg::ST_PTR_B: begin
        ptr_rd.en  = 1'b1;
        ptr_rd.idx = cne_pkg::IDX_W'(seed_r) + cne_pkg::IDX_W'(1);
      end
      cne_pkg::ST_PTR_E: ;
      cne_pkg::ST_CHECK: begin
        nbr_rd.en  = check_ok;
        nbr_rd.idx = cne_pkg::IDX_W'(begin_r);
      end
      cne_pkg::ST_NOUT: begin
        out_load  = out_free;
        nbr_rd.en = out_free && !rem_last;
      end
      cne_pkg::ST_STATUS: out_load = out_free;
      default: ;
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cne_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      batch_len_r <= '0;
      row_cnt_r   <= '0;
      edge_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Begin batch saturates length and clears counters
      if (in_fire && in_ch.kind == cne_pkg::KIND_BEGIN) begin
        batch_len_r <= (in_ch.value > 16'(cne_pkg::BATCH_MAX)) ?
                       cne_pkg::BATCH_MAX : in_ch.value[cne_pkg::CNT_W-1:0];
        row_cnt_r   <= '0;
        edge_cnt_r  <= '0;
      end else if (in_fire && in_ch.kind == cne_pkg::KIND_EXPAND) begin
        if (row_cnt_r != cne_pkg::BATCH_MAX) begin
          row_cnt_r <= row_cnt_r + cne_pkg::CNT_W'(1);
        end
      end else if (state_r == cne_pkg::ST_CHECK && check_ok) begin
        edge_cnt_r <= edge_cnt_r + cne_pkg::EDGE_W'(deg_r);
      end
    end
  end

  // Expansion datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      cne_pkg::ST_IDLE: begin
        if (in_fire && in_ch.kind == cne_pkg::KIND_EXPAND) begin
          seed_r   <= in_ch.value;
          row_r    <= row_cnt_r[cne_pkg::ROW_W-1:0];
          base_r   <= cne_pkg::BASE_W'(batch_len_r) + cne_pkg::BASE_W'(edge_cnt_r);
          status_r <= seed_bad ? cne_pkg::STAT_EMPTY : cne_pkg::STAT_OK;
        end
      end
      cne_pkg::ST_PTR_B: begin
        begin_r <= ptr_rd_data;
      end
      cne_pkg::ST_PTR_E: begin
        deg_r <= DEG_W1'(ptr_diff);
        if (ptr_empty) begin
          status_r <= cne_pkg::STAT_EMPTY;
        end else if (deg_big) begin
          status_r <= cne_pkg::STAT_DEGREE;
        end
      end
      cne_pkg::ST_CHECK: begin
        if (status_r == cne_pkg::STAT_OK && col_ovf) begin
          status_r <= cne_pkg::STAT_OVERFLOW;
        end
        weight_r  <= weight_tab[DEG_W'(deg_r - DEG_W1'(1))];
        col_r     <= base_r[cne_pkg::COL_W-1:0];
        rem_r     <= deg_r;
        nbr_idx_r <= cne_pkg::IDX_W'(begin_r) + cne_pkg::IDX_W'(1);
      end
      cne_pkg::ST_NOUT: begin
        if (out_load) begin
          out_nbr_r    <= nbr_rd_data;
          out_row_r    <= row_r;
          out_col_r    <= col_r;
          out_weight_r <= weight_r;
          out_status_r <= cne_pkg::STAT_OK;
          out_last_r   <= rem_last;
          col_r        <= col_r + cne_pkg::COL_W'(1);
          rem_r        <= rem_r - DEG_W1'(1);
          nbr_idx_r    <= nbr_idx_r + cne_pkg::IDX_W'(1);
        end
      end
      cne_pkg::ST_STATUS: begin
        if (out_load) begin
          out_nbr_r    <= '0;
          out_row_r    <= row_r;
          out_col_r    <= '0;
          out_weight_r <= '0;
          out_status_r <= status_r;
          out_last_r   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Channel ports
  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.neighbor = out_nbr_r;
  assign out_ch.row      = out_row_r;
  assign out_ch.column   = out_col_r;
  assign out_ch.weight   = out_weight_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  // A pending result is never overwritten while the sink stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("result register overwritten during stall");

  // The final neighbor result ends the expansion
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cne_pkg::ST_NOUT && out_load && rem_last) |=>
      (state_r == cne_pkg::ST_IDLE && out_valid_r && out_last_r))
    else $error("expansion did not end on its last result");

  // Each expand item advances the row counter until saturation
  a_row_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.kind == cne_pkg::KIND_EXPAND && row_cnt_r != cne_pkg::BATCH_MAX)
      |=> (row_cnt_r == cne_pkg::CNT_W'($past(row_cnt_r) + cne_pkg::CNT_W'(1))))
    else $error("row counter did not advance");

  // Edge counter moves only on begin batch or a successful check
  a_edge_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_fire && in_ch.kind == cne_pkg::KIND_BEGIN) && state_r != cne_pkg::ST_CHECK)
      |=> $stable(edge_cnt_r))
    else $error("edge counter changed outside begin or check");

endmodule

`default_nettype wire
